// File: design/spqvt_pkg.sv
// Shared types, constants and fixed-point helpers for the sprite quad vertex transform.
`default_nettype none
package spqvt_pkg;

    localparam int IN_W  = 200;
    localparam int OUT_W = 112;

    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [30:0] TRIG_ONE  = 31'h4000_0000;
    localparam logic [14:0] Q14_ONE   = 15'd16384;
    localparam logic [16:0] UV_MAX    = 17'h1FFFF;
    localparam int          DIV_STEPS = 17;
    localparam logic [1:0]  CORNER_LAST = 2'd3;

    typedef enum logic [0:0] {
        REG_VERTEX_COLOR = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [23:0]        tex_size;
        logic [15:0]        angle;
        logic [15:0]        scale_y;
        logic [15:0]        scale_x;
        logic signed [16:0] pivot_y;
        logic signed [16:0] pivot_x;
        logic [11:0]        src_h;
        logic [11:0]        src_w;
        logic [11:0]        src_y;
        logic [11:0]        src_x;
        logic signed [19:0] dest_y;
        logic signed [19:0] dest_x;
    } in_t;

    typedef struct packed {
        logic [30:0]      x;
        logic [31:0]      x2;
        logic [1:0]       quad;
        logic [1:0][31:0] p;
        logic [1:0][61:0] prod;
        logic [1:0][30:0] t;
    } trig_t;

    typedef struct packed {
        logic [3:0][12:0] rem;
        logic [3:0][16:0] q;
        logic [3:0][11:0] size;
        logic [3:0]       sat;
    } div_t;

    function automatic logic [29:0] trig_recip(input logic lane, input logic [1:0] k);
        logic [29:0] m;
        case ({lane, k})
            3'd0:    m = 30'd59652323;
            3'd1:    m = 30'd102261126;
            3'd2:    m = 30'd214748364;
            3'd3:    m = 30'd715827882;
            3'd4:    m = 30'd47721858;
            3'd5:    m = 30'd76695844;
            3'd6:    m = 30'd143165576;
            default: m = 30'd357913941;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] trig_div(input logic lane, input logic [1:0] k);
        logic [6:0] d;
        case ({lane, k})
            3'd0:    d = 7'd72;
            3'd1:    d = 7'd42;
            3'd2:    d = 7'd20;
            3'd3:    d = 7'd6;
            3'd4:    d = 7'd90;
            3'd5:    d = 7'd56;
            3'd6:    d = 7'd30;
            default: d = 7'd12;
        endcase
        return d;
    endfunction

    function automatic logic [14:0] q30_to_q14(input logic [31:0] v);
        logic [32:0] r;
        r = (33'(v) + 33'd32768) >> 16;
        return (r > 33'(Q14_ONE)) ? Q14_ONE : r[14:0];
    endfunction

endpackage
`default_nettype wire

// File: design/sprite_quad_vertex_transform_core.sv
// Sprite quad vertex transform: one sprite in, four screen/texture vertices out.
//
// s_tdata carries one sprite per beat; m_tdata/m_tuser/m_tlast carry one vertex per
// beat in the order top-left, top-right, bottom-left, bottom-right, m_tlast on the
// fourth. The APB port holds the vertex colour copied to every vertex.
// Pipeline: 20 stages (sine/cosine series, per-axis scale, rotation products,
// rounding, and a restoring divider for the texture coordinates in parallel);
// the last stage loads the output serializer, which registers the first vertex.
// The four-beat output serializer loads the next sprite as the last vertex of the
// current one is taken; the pipeline itself takes one sprite per cycle unless stalled.
// Reset clears all valid bits and the serializer and sets the colour to all ones.
// When the receiver stalls, the serializer holds its vertex; once the last pipeline
// stage is also full the whole pipeline holds and s_tready drops.
`default_nettype none
module sprite_quad_vertex_transform_core #(
    parameter int POS_FRAC_BITS = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // dest_x, dest_y, src_x, src_y, src_w, src_h, pivot_x, pivot_y,
    // scale_x, scale_y, angle, tex_size, zero fill
    input  wire logic [spqvt_pkg::IN_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // pos_x, pos_y, tex_u, tex_v, color, zero fill
    output logic [spqvt_pkg::OUT_W-1:0]      m_tdata,
    // corner
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int FIN     = 19;
    localparam int ST_SC   = 15;
    localparam int TRIG_ST = 13;
    localparam int OX_W    = ((17 > 13 + POS_FRAC_BITS) ? 17 : 13 + POS_FRAC_BITS) + 1;
    localparam int XS_W    = OX_W + 17;
    localparam int BASE_W  = 44;
    localparam int P_W     = XS_W + 16;
    localparam int SUM_W   = ((P_W > BASE_W) ? P_W : BASE_W) + 2;
    localparam logic signed [BASE_W-1:0] HALF = BASE_W'(64'd1 << (POS_FRAC_BITS + 21));
    localparam logic signed [SUM_W-1:0]  RND  = SUM_W'(2097152);
    localparam logic signed [SUM_W-1:0]  PMAX = SUM_W'(524287);
    localparam logic signed [SUM_W-1:0]  PMIN = SUM_W'(-524288);

    typedef struct packed {
        logic signed [XS_W-1:0]   xs0;
        logic signed [XS_W-1:0]   xs1;
        logic signed [XS_W-1:0]   ys0;
        logic signed [XS_W-1:0]   ys1;
        logic signed [BASE_W-1:0] bx;
        logic signed [BASE_W-1:0] by;
    } geo_t;

    logic [FIN:0]  v_reg;
    logic [FIN:0]  v_next;
    logic          adv;
    logic          ld;
    logic          ser_valid_reg;
    logic          ser_valid_next;
    logic [1:0]    corner_reg;
    logic [1:0]    corner_next;
    logic [31:0]   color_reg;

    spqvt_pkg::in_t in_reg;

    spqvt_pkg::trig_t trig_reg  [0:TRIG_ST-1];
    spqvt_pkg::trig_t trig_next [0:TRIG_ST-1];
    logic [30:0]  sv_reg;
    logic [31:0]  hp_reg;
    logic [1:0]   quad14_reg;
    logic [14:0]  s_reg;
    logic [14:0]  c_reg;
    logic [1:0]   quad15_reg;
    logic signed [15:0] sn_reg;
    logic signed [15:0] cs_reg;
    logic signed [15:0] sn_next;
    logic signed [15:0] cs_next;

    logic signed [OX_W-1:0]   ox_reg [2];
    logic signed [OX_W-1:0]   oy_reg [2];
    logic signed [BASE_W-1:0] bx1_reg;
    logic signed [BASE_W-1:0] by1_reg;
    logic [15:0]              sx1_reg;
    logic [15:0]              sy1_reg;
    geo_t                     geo_reg [2:16];
    geo_t                     geo_next;

    logic signed [P_W-1:0]    xc_reg [2];
    logic signed [P_W-1:0]    xn_reg [2];
    logic signed [P_W-1:0]    yc_reg [2];
    logic signed [P_W-1:0]    yn_reg [2];
    logic signed [BASE_W-1:0] bx17_reg;
    logic signed [BASE_W-1:0] by17_reg;
    logic signed [SUM_W-1:0]  sum_px_reg [4];
    logic signed [SUM_W-1:0]  sum_py_reg [4];
    logic [19:0]              fin_px_reg [4];
    logic [19:0]              fin_py_reg [4];
    logic [19:0]              fin_px_next [4];
    logic [19:0]              fin_py_next [4];

    spqvt_pkg::div_t div_init;
    spqvt_pkg::div_t dv_in   [1:FIN];
    spqvt_pkg::div_t dv_next [1:FIN];
    spqvt_pkg::div_t dv_reg  [1:FIN];

    logic [19:0] ser_px_reg [4];
    logic [19:0] ser_py_reg [4];
    logic [16:0] ser_u_reg  [2];
    logic [16:0] ser_v_reg  [2];

    // handshake and serializer control
    assign ld       = v_reg[FIN] && (!ser_valid_reg || (m_tready && corner_reg == spqvt_pkg::CORNER_LAST));
    assign adv      = !v_reg[FIN] || ld;
    assign s_tready = adv;
    assign v_next   = {v_reg[FIN-1:0], s_tvalid};

    always_comb begin
        ser_valid_next = ser_valid_reg;
        corner_next    = corner_reg;
        if (m_tvalid && m_tready) begin
            corner_next = corner_reg + 2'd1;
            if (corner_reg == spqvt_pkg::CORNER_LAST) begin
                ser_valid_next = 1'b0;
            end
        end
        if (ld) begin
            ser_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            ser_valid_reg <= 1'b0;
            corner_reg    <= 2'd0;
            color_reg     <= 32'hFFFF_FFFF;
        end else begin
            if (adv) begin
                v_reg <= v_next;
            end
            ser_valid_reg <= ser_valid_next;
            corner_reg    <= corner_next;
            if (psel && penable && pwrite && pready &&
                paddr[2] == spqvt_pkg::REG_VERTEX_COLOR) begin
                color_reg <= pwdata;
            end
        end
    end

    // configuration read
    assign pready = 1'b1;
    always_comb begin
        case (spqvt_pkg::reg_idx_t'(paddr[2]))
            spqvt_pkg::REG_VERTEX_COLOR: prdata = color_reg;
            default:                     prdata = 32'd0;
        endcase
    end

    // sine and cosine series
    for (genvar j = 0; j < TRIG_ST; j++) begin : g_trig
        localparam int JJ = j - 2;
        localparam bit IS_A = (j >= 2) && ((JJ == 0) || ((JJ - 1) % 3 == 2));
        localparam bit IS_B = (j >= 2) && (JJ >= 1) && ((JJ - 1) % 3 == 0);
        localparam logic [1:0] KA = 2'((JJ < 0) ? 0 : JJ / 3);
        localparam logic [1:0] KB = 2'((JJ < 1) ? 0 : (JJ - 1) / 3);
        if (j == 0) begin : g_x
            always_comb begin
                logic [45:0] xp;
                xp = 46'(in_reg.angle[13:0]) * 46'(spqvt_pkg::PI_Q30);
                trig_next[j]      = '0;
                trig_next[j].x    = xp[45:15];
                trig_next[j].quad = in_reg.angle[15:14];
            end
        end else if (j == 1) begin : g_x2
            always_comb begin
                logic [61:0] sq;
                sq = 62'(trig_reg[j-1].x) * 62'(trig_reg[j-1].x);
                trig_next[j]    = trig_reg[j-1];
                trig_next[j].x2 = sq[61:30];
            end
        end else if (IS_A) begin : g_a
            always_comb begin
                logic [31:0] pa;
                trig_next[j] = trig_reg[j-1];
                for (int l = 0; l < 2; l++) begin
                    pa = (JJ == 0) ? trig_reg[j-1].x2 : trig_reg[j-1].p[l];
                    trig_next[j].p[l]    = pa;
                    trig_next[j].prod[l] = 62'(pa) * 62'(spqvt_pkg::trig_recip(l[0], KA));
                end
            end
        end else if (IS_B) begin : g_b
            always_comb begin
                logic [29:0] q0;
                logic [29:0] qc;
                logic [36:0] m;
                logic [37:0] rem;
                logic [6:0]  d;
                trig_next[j] = trig_reg[j-1];
                for (int l = 0; l < 2; l++) begin
                    d   = spqvt_pkg::trig_div(l[0], KB);
                    q0  = trig_reg[j-1].prod[l][61:32];
                    m   = 37'(q0) * 37'(d);
                    rem = 38'(trig_reg[j-1].p[l]) - 38'(m);
                    qc  = (rem >= 38'(d)) ? q0 + 30'd1 : q0;
                    trig_next[j].t[l] = spqvt_pkg::TRIG_ONE - 31'(qc);
                end
            end
        end else begin : g_c
            always_comb begin
                logic [62:0] pm;
                trig_next[j] = trig_reg[j-1];
                for (int l = 0; l < 2; l++) begin
                    pm = 63'(trig_reg[j-1].x2) * 63'(trig_reg[j-1].t[l]);
                    trig_next[j].p[l] = pm[61:30];
                end
            end
        end
    end

    always_comb begin
        case (spqvt_pkg::quad_t'(quad15_reg))
            spqvt_pkg::QUAD_0: begin
                sn_next = 16'(s_reg);
                cs_next = 16'(c_reg);
            end
            spqvt_pkg::QUAD_1: begin
                sn_next = 16'(c_reg);
                cs_next = -16'(s_reg);
            end
            spqvt_pkg::QUAD_2: begin
                sn_next = -16'(s_reg);
                cs_next = -16'(c_reg);
            end
            default: begin
                sn_next = -16'(c_reg);
                cs_next = 16'(s_reg);
            end
        endcase
    end

    // texture coordinate divider
    always_comb begin
        logic [12:0] e [4];
        e[0] = 13'(in_reg.src_x);
        e[1] = 13'(in_reg.src_x) + 13'(in_reg.src_w);
        e[2] = 13'(in_reg.src_y);
        e[3] = 13'(in_reg.src_y) + 13'(in_reg.src_h);
        div_init = '0;
        for (int l = 0; l < 4; l++) begin
            div_init.size[l] = (l < 2) ? in_reg.tex_size[23:12] : in_reg.tex_size[11:0];
            div_init.rem[l]  = e[l];
            div_init.sat[l]  = (div_init.size[l] == 12'd0) || (e[l] >= {div_init.size[l], 1'b0});
        end
    end

    for (genvar n = 1; n <= FIN; n++) begin : g_div
        if (n == 1) begin : g_first
            assign dv_in[n] = div_init;
        end else begin : g_rest
            assign dv_in[n] = dv_reg[n-1];
        end
        always_comb begin
            logic [12:0] r2;
            logic        bit_q;
            dv_next[n] = dv_in[n];
            for (int s = 0; s < 2; s++) begin
                if (2 * (n - 1) + s < spqvt_pkg::DIV_STEPS) begin
                    for (int l = 0; l < 4; l++) begin
                        r2 = (2 * (n - 1) + s == 0) ? dv_next[n].rem[l] : (dv_next[n].rem[l] << 1);
                        bit_q = (r2 >= 13'(dv_next[n].size[l]));
                        dv_next[n].rem[l] = bit_q ? r2 - 13'(dv_next[n].size[l]) : r2;
                        dv_next[n].q[l]   = {dv_next[n].q[l][15:0], bit_q};
                    end
                end
            end
        end
    end

    // scale, rotate, translate
    always_comb begin
        geo_next.xs0 = XS_W'(ox_reg[0]) * XS_W'(signed'({1'b0, sx1_reg}));
        geo_next.xs1 = XS_W'(ox_reg[1]) * XS_W'(signed'({1'b0, sx1_reg}));
        geo_next.ys0 = XS_W'(oy_reg[0]) * XS_W'(signed'({1'b0, sy1_reg}));
        geo_next.ys1 = XS_W'(oy_reg[1]) * XS_W'(signed'({1'b0, sy1_reg}));
        geo_next.bx  = bx1_reg;
        geo_next.by  = by1_reg;
    end

    always_comb begin
        logic signed [SUM_W-1:0] rnd;
        logic signed [SUM_W-1:0] sh;
        for (int k = 0; k < 4; k++) begin
            rnd = sum_px_reg[k] + RND;
            sh  = rnd >>> 22;
            fin_px_next[k] = (sh > PMAX) ? PMAX[19:0] : ((sh < PMIN) ? PMIN[19:0] : sh[19:0]);
            rnd = sum_py_reg[k] + RND;
            sh  = rnd >>> 22;
            fin_py_next[k] = (sh > PMAX) ? PMAX[19:0] : ((sh < PMIN) ? PMIN[19:0] : sh[19:0]);
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [20:0]      bsx;
        logic signed [20:0]      bsy;
        logic signed [OX_W-1:0]  o0;
        logic [OX_W-1:0]         twp;
        logic [OX_W-1:0]         thp;
        logic signed [XS_W-1:0]  xsel;
        logic signed [XS_W-1:0]  ysel;
        logic [31:0]             hv;
        logic [61:0]             sp;
        logic [62:0]             cp;
        if (adv) begin
            if (s_tvalid) begin
                in_reg <= spqvt_pkg::in_t'(s_tdata);
            end
            for (int j = 0; j < TRIG_ST; j++) begin
                trig_reg[j] <= trig_next[j];
            end
            sp = 62'(trig_reg[TRIG_ST-1].x) * 62'(trig_reg[TRIG_ST-1].t[0]);
            cp = 63'(trig_reg[TRIG_ST-1].x2) * 63'(trig_reg[TRIG_ST-1].t[1]);
            sv_reg     <= sp[60:30];
            hp_reg     <= cp[61:30];
            quad14_reg <= trig_reg[TRIG_ST-1].quad;
            hv = 32'(hp_reg[31:1]);
            s_reg      <= spqvt_pkg::q30_to_q14(32'(sv_reg));
            c_reg      <= spqvt_pkg::q30_to_q14((hv >= 32'(spqvt_pkg::TRIG_ONE)) ? 32'd0 :
                                                32'(spqvt_pkg::TRIG_ONE) - hv);
            quad15_reg <= quad14_reg;
            sn_reg     <= sn_next;
            cs_reg     <= cs_next;

            o0  = -OX_W'(in_reg.pivot_x);
            twp = OX_W'(in_reg.src_w) << POS_FRAC_BITS;
            ox_reg[0] <= o0;
            ox_reg[1] <= o0 + signed'(twp);
            o0  = -OX_W'(in_reg.pivot_y);
            thp = OX_W'(in_reg.src_h) << POS_FRAC_BITS;
            oy_reg[0] <= o0;
            oy_reg[1] <= o0 + signed'(thp);
            bsx = 21'(in_reg.dest_x) + 21'(in_reg.pivot_x);
            bsy = 21'(in_reg.dest_y) + 21'(in_reg.pivot_y);
            bx1_reg <= (BASE_W'(bsx) <<< 22) - HALF;
            by1_reg <= (BASE_W'(bsy) <<< 22) - HALF;
            sx1_reg <= in_reg.scale_x;
            sy1_reg <= in_reg.scale_y;
            geo_reg[2] <= geo_next;
            for (int n = 3; n <= 16; n++) begin
                geo_reg[n] <= geo_reg[n-1];
            end

            for (int i = 0; i < 2; i++) begin
                xsel = (i == 0) ? geo_reg[16].xs0 : geo_reg[16].xs1;
                ysel = (i == 0) ? geo_reg[16].ys0 : geo_reg[16].ys1;
                xc_reg[i] <= P_W'(xsel) * P_W'(cs_reg);
                xn_reg[i] <= P_W'(xsel) * P_W'(sn_reg);
                yc_reg[i] <= P_W'(ysel) * P_W'(cs_reg);
                yn_reg[i] <= P_W'(ysel) * P_W'(sn_reg);
            end
            bx17_reg <= geo_reg[16].bx;
            by17_reg <= geo_reg[16].by;
            for (int k = 0; k < 4; k++) begin
                sum_px_reg[k] <= SUM_W'(xc_reg[k % 2]) - SUM_W'(yn_reg[k / 2]) + SUM_W'(bx17_reg);
                sum_py_reg[k] <= SUM_W'(xn_reg[k % 2]) + SUM_W'(yc_reg[k / 2]) + SUM_W'(by17_reg);
                fin_px_reg[k] <= fin_px_next[k];
                fin_py_reg[k] <= fin_py_next[k];
            end
            for (int n = 1; n <= FIN; n++) begin
                dv_reg[n] <= dv_next[n];
            end
        end
        if (ld) begin
            for (int k = 0; k < 4; k++) begin
                ser_px_reg[k] <= fin_px_reg[k];
                ser_py_reg[k] <= fin_py_reg[k];
            end
            for (int i = 0; i < 2; i++) begin
                ser_u_reg[i] <= dv_reg[FIN].sat[i] ? spqvt_pkg::UV_MAX : dv_reg[FIN].q[i];
                ser_v_reg[i] <= dv_reg[FIN].sat[i+2] ? spqvt_pkg::UV_MAX : dv_reg[FIN].q[i+2];
            end
        end
    end

    // vertex output
    assign m_tvalid = ser_valid_reg;
    assign m_tuser  = corner_reg;
    assign m_tlast  = (corner_reg == spqvt_pkg::CORNER_LAST);
    assign m_tdata  = {6'd0, color_reg, ser_v_reg[corner_reg[1]], ser_u_reg[corner_reg[0]],
                       ser_py_reg[corner_reg], ser_px_reg[corner_reg]};

`ifndef SYNTH
    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> corner_reg == 2'd0)
        else $error("corner did not wrap after last vertex");
    a_corner_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && corner_reg == $past(corner_reg) + 2'd1)
        else $error("vertex sequence broken");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[FIN] |-> s_tready)
        else $error("input stalled with empty final stage");
    a_trig_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_SC] |-> (s_reg <= spqvt_pkg::Q14_ONE) && (c_reg <= spqvt_pkg::Q14_ONE))
        else $error("sine or cosine out of range");
    a_start_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> corner_reg == 2'd0)
        else $error("sprite did not start at first corner");
`endif

endmodule
`default_nettype wire

// File: verif/tb_sprite_quad_vertex_transform_core.sv
// Self-checking testbench for the sprite quad vertex transform core.
module tb_sprite_quad_vertex_transform_core;

    typedef struct {
        logic [1:0]  corner;
        logic [19:0] pos_x;
        logic [19:0] pos_y;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [31:0] color;
        logic        last;
    } vertex_t;

    class vertex_scoreboard;
        vertex_t     pending_q[$];
        logic [31:0] color;
        int          errors;

        function new();
            color  = 32'hFFFF_FFFF;
            errors = 0;
        endfunction

        function longint unsigned to_q14(longint unsigned v);
            longint unsigned r;
            r = (v + 64'd32768) >> 16;
            return (r > 64'd16384) ? 64'd16384 : r;
        endfunction

        function void sin_cos(logic [15:0] a, output longint sn, output longint cs);
            longint unsigned one, r, x, x2, t, h, s, c;
            one = 64'd1 << 30;
            r   = longint'(a[13:0]);
            x   = (r * 64'd3373259426) >> 15;
            x2  = (x * x) >> 30;
            t = one - x2 / 72;
            t = one - ((x2 * t) >> 30) / 42;
            t = one - ((x2 * t) >> 30) / 20;
            t = one - ((x2 * t) >> 30) / 6;
            s = to_q14((x * t) >> 30);
            t = one - x2 / 90;
            t = one - ((x2 * t) >> 30) / 56;
            t = one - ((x2 * t) >> 30) / 30;
            t = one - ((x2 * t) >> 30) / 12;
            h = ((x2 * t) >> 30) / 2;
            c = to_q14(h >= one ? 64'd0 : one - h);
            case (spqvt_pkg::quad_t'(a[15:14]))
                spqvt_pkg::QUAD_0: begin sn = s;  cs = c;  end
                spqvt_pkg::QUAD_1: begin sn = c;  cs = -s; end
                spqvt_pkg::QUAD_2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        endfunction

        function logic [19:0] round_pos(longint v);
            longint r;
            r = (v + (64'sd1 <<< 21)) >>> 22;
            if (r > 524287) r = 524287;
            if (r < -524288) r = -524288;
            return r[19:0];
        endfunction

        function logic [16:0] uv_of(longint unsigned edge_pos, longint unsigned size);
            longint unsigned q;
            if (size == 0) return spqvt_pkg::UV_MAX;
            q = (edge_pos << 16) / size;
            return (q > 64'd131071) ? spqvt_pkg::UV_MAX : q[16:0];
        endfunction

        function void note_sprite(spqvt_pkg::in_t d);
            longint sn, cs, cx, cy, sx, sy, base_x, base_y, xs, ys;
            longint ox[2], oy[2];
            logic [16:0] u[2], v[2];
            vertex_t e;
            sin_cos(d.angle, sn, cs);
            cx = longint'($signed(d.pivot_x));
            cy = longint'($signed(d.pivot_y));
            sx = longint'(d.scale_x);
            sy = longint'(d.scale_y);
            ox[0] = -cx;
            ox[1] = -cx + longint'(d.src_w) * 16;
            oy[0] = -cy;
            oy[1] = -cy + longint'(d.src_h) * 16;
            u[0] = uv_of(longint'(d.src_x), longint'(d.tex_size[23:12]));
            u[1] = uv_of(longint'(d.src_x) + longint'(d.src_w), longint'(d.tex_size[23:12]));
            v[0] = uv_of(longint'(d.src_y), longint'(d.tex_size[11:0]));
            v[1] = uv_of(longint'(d.src_y) + longint'(d.src_h), longint'(d.tex_size[11:0]));
            base_x = (longint'($signed(d.dest_x)) + cx) * (64'sd1 <<< 22) - (64'sd1 <<< 25);
            base_y = (longint'($signed(d.dest_y)) + cy) * (64'sd1 <<< 22) - (64'sd1 <<< 25);
            for (int k = 0; k < 4; k++) begin
                xs       = ox[k & 1] * sx;
                ys       = oy[(k >> 1) & 1] * sy;
                e.corner = k[1:0];
                e.pos_x  = round_pos(xs * cs - ys * sn + base_x);
                e.pos_y  = round_pos(xs * sn + ys * cs + base_y);
                e.tex_u  = u[k & 1];
                e.tex_v  = v[(k >> 1) & 1];
                e.color  = color;
                e.last   = (k[1:0] == spqvt_pkg::CORNER_LAST);
                pending_q.push_back(e);
            end
        endfunction

        function void check_vertex(logic [1:0] corner, logic [spqvt_pkg::OUT_W-1:0] data,
                                   logic last);
            vertex_t e;
            if (pending_q.size() == 0) begin
                $error("vertex beat with no expected vertex: corner %0d", corner);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (corner !== e.corner) begin
                $error("corner: expected %0d, got %0d", e.corner, corner); errors++;
            end
            if (data[19:0] !== e.pos_x) begin
                $error("pos_x: expected %h, got %h", e.pos_x, data[19:0]); errors++;
            end
            if (data[39:20] !== e.pos_y) begin
                $error("pos_y: expected %h, got %h", e.pos_y, data[39:20]); errors++;
            end
            if (data[56:40] !== e.tex_u) begin
                $error("tex_u: expected %h, got %h", e.tex_u, data[56:40]); errors++;
            end
            if (data[73:57] !== e.tex_v) begin
                $error("tex_v: expected %h, got %h", e.tex_v, data[73:57]); errors++;
            end
            if (data[105:74] !== e.color) begin
                $error("color: expected %h, got %h", e.color, data[105:74]); errors++;
            end
            if (last !== e.last) begin
                $error("last_corner: expected %0d, got %0d", e.last, last); errors++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [spqvt_pkg::IN_W-1:0]       s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [spqvt_pkg::OUT_W-1:0]      m_tdata;
    logic [1:0]                       m_tuser;
    logic                             m_tlast;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [2:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;

    vertex_scoreboard vertex_sb = new();
    bit  idle_on = 1;
    int  hold_cycles = 0;
    int  cycle_count = 0;

    sprite_quad_vertex_transform_core dut (.*);

    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) vertex_sb.check_vertex(m_tuser, m_tdata, m_tlast);
    end

    int ready_gap = 0;
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_color(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * spqvt_pkg::REG_VERTEX_COLOR);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vertex_sb.color = value;
    endtask

    task automatic send_sprite(spqvt_pkg::in_t d, bit gaps);
        int n;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        vertex_sb.note_sprite(d);
        if (gaps && idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (vertex_sb.pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic spqvt_pkg::in_t random_sprite();
        spqvt_pkg::in_t d;
        d = spqvt_pkg::IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom});
        d.pad = '0;
        case ($urandom_range(0, 4))
            0: ;
            1, 2: begin
                d.scale_x  = 16'($urandom_range(64, 1024));
                d.scale_y  = 16'($urandom_range(64, 1024));
                d.src_w    = 12'($urandom_range(1, 256));
                d.src_h    = 12'($urandom_range(1, 256));
                d.src_x    = 12'($urandom_range(0, 1024));
                d.src_y    = 12'($urandom_range(0, 1024));
                d.tex_size = {12'($urandom_range(256, 2048)), 12'($urandom_range(256, 2048))};
                d.pivot_x  = 17'($urandom_range(0, 4096));
                d.pivot_y  = 17'($urandom_range(0, 4096));
            end
            3: d.tex_size[$urandom_range(0, 1) ? 23 : 11 -: 12] = '0;
            default: d.angle = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        endcase
        return d;
    endfunction

    function automatic spqvt_pkg::in_t plain_sprite();
        spqvt_pkg::in_t d;
        d = '0;
        d.dest_x   = 20'sd1600;
        d.dest_y   = 20'sd800;
        d.src_x    = 12'd16;
        d.src_y    = 12'd32;
        d.src_w    = 12'd64;
        d.src_h    = 12'd48;
        d.pivot_x  = 17'sd512;
        d.pivot_y  = 17'sd384;
        d.scale_x  = 16'd256;
        d.scale_y  = 16'd256;
        d.tex_size = {12'd256, 12'd256};
        return d;
    endfunction

    initial begin
        spqvt_pkg::in_t d;
        spqvt_pkg::in_t directed[$];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        d = '0; directed.push_back(d);
        d = '1; d.pad = '0; directed.push_back(d);
        for (int a = 0; a < 8; a++) begin
            d = plain_sprite(); d.angle = 16'(a * 8192); directed.push_back(d);
        end
        d = plain_sprite(); d.angle = 16'hFFFF; directed.push_back(d);
        d = plain_sprite(); d.tex_size[23:12] = '0; directed.push_back(d);
        d = plain_sprite(); d.tex_size[11:0] = '0; directed.push_back(d);
        d = plain_sprite(); d.src_x = 12'd4095; d.src_w = 12'd4095;
        d.tex_size = {12'd1, 12'd3}; directed.push_back(d);
        d = plain_sprite(); d.scale_x = '0; d.scale_y = 16'hFFFF; directed.push_back(d);
        d = plain_sprite(); d.dest_x = 20'sh7FFFF; d.dest_y = 20'sh7FFFF;
        d.pivot_x = 17'sh0FFFF; d.pivot_y = 17'sh0FFFF; directed.push_back(d);
        d = plain_sprite(); d.dest_x = 20'sh80000; d.dest_y = 20'sh80000;
        d.pivot_x = 17'sh10000; d.pivot_y = 17'sh10000; directed.push_back(d);
        d = plain_sprite(); d.scale_x = 16'hFFFF; d.scale_y = 16'hFFFF;
        d.src_w = 12'd4095; d.src_h = 12'd4095; d.angle = 16'd8192; directed.push_back(d);
        d = plain_sprite(); d.pivot_x = 17'sh10000; d.pivot_y = 17'sh0FFFF;
        d.scale_x = 16'hFFFF; d.scale_y = 16'hFFFF; d.angle = 16'd40000;
        directed.push_back(d);
        foreach (directed[i]) send_sprite(directed[i], 1);
        drain();

        write_color(32'h0000_0000);
        repeat (25) send_sprite(random_sprite(), 1);
        drain();

        write_color($urandom);
        hold_cycles = 300;
        repeat (30) send_sprite(random_sprite(), 0);
        drain();

        write_color($urandom);
        repeat (20) send_sprite(random_sprite(), 1);
        drain();

        idle_on = 0;
        write_color(32'hFFFF_FFFF);
        repeat (25) send_sprite(random_sprite(), 1);
        drain();

        if (vertex_sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: sprite_quad_vertex_transform_core.f
design/spqvt_pkg.sv
design/sprite_quad_vertex_transform_core.sv
verif/tb_sprite_quad_vertex_transform_core.sv
